// ===== design/tcss_pkg.sv =====
// shared types and codes for the tcp connection state step block
package tcss_pkg;

   typedef enum logic [3:0] {
      ST_CLOSED      = 4'd0,
      ST_LISTEN      = 4'd1,
      ST_SYN_RECV    = 4'd2,
      ST_SYN_SENT    = 4'd3,
      ST_ESTABLISHED = 4'd4,
      ST_CLOSE_WAIT  = 4'd5,
      ST_LAST_ACK    = 4'd6,
      ST_FIN_WAIT_1  = 4'd7,
      ST_FIN_WAIT_2  = 4'd8,
      ST_CLOSING     = 4'd9,
      ST_TIME_WAIT   = 4'd10
   } conn_state_type;

   typedef enum logic [1:0] {
      RP_NONE   = 2'd0,
      RP_RESET  = 2'd1,
      RP_ACK    = 2'd2,
      RP_SYNACK = 2'd3
   } reply_type;

   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_CONNECTED = 3'd1,
      EV_SPAWN     = 3'd2,
      EV_ACCEPT    = 3'd3,
      EV_TIMEWAIT  = 3'd4,
      EV_RESET     = 3'd5
   } event_type;

   typedef enum logic [0:0] {
      OP_SEGMENT   = 1'b0,
      OP_SET_STATE = 1'b1
   } op_type;

   // flag bit positions
   localparam int unsigned FL_FIN = 0;
   localparam int unsigned FL_SYN = 1;
   localparam int unsigned FL_RST = 2;
   localparam int unsigned FL_ACK = 4;

   localparam logic [5:0] FLAGS_ACK_ONLY = 6'b01_0000;

   typedef struct packed {
      logic        op;
      logic [3:0]  new_state;
      logic [31:0] seg_seq;
      logic [31:0] seg_seq_end;
      logic [31:0] seg_ack;
      logic [5:0]  seg_flags;
      logic [31:0] send_next;
      logic [15:0] recv_window;
   } req_type;

   typedef struct packed {
      conn_state_type conn_state;
      logic [31:0]    recv_next;
      logic [31:0]    send_unacked;
   } conn_type;

   typedef struct packed {
      conn_state_type conn_state;
      reply_type      reply_kind;
      logic           segment_dropped;
      event_type      event_kind;
      logic [31:0]    recv_next_out;
      logic [31:0]    send_unacked_out;
   } rsp_type;

endpackage

// ===== design/tcss_if.sv =====
// request and result channel interfaces of the tcp connection state step block
interface tcss_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [3:0]  new_state;
   logic [31:0] seg_seq;
   logic [31:0] seg_seq_end;
   logic [31:0] seg_ack;
   logic [5:0]  seg_flags;
   logic [31:0] send_next;
   logic [15:0] recv_window;

   modport source (
      output valid, op, new_state, seg_seq, seg_seq_end, seg_ack, seg_flags,
             send_next, recv_window,
      input  ready
   );
   modport sink (
      input  valid, op, new_state, seg_seq, seg_seq_end, seg_ack, seg_flags,
             send_next, recv_window,
      output ready
   );
endinterface

interface tcss_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  conn_state;
   logic [1:0]  reply_kind;
   logic        segment_dropped;
   logic [2:0]  event_kind;
   logic [31:0] recv_next_out;
   logic [31:0] send_unacked_out;

   modport source (
      output valid, conn_state, reply_kind, segment_dropped, event_kind,
             recv_next_out, send_unacked_out,
      input  ready
   );
   modport sink (
      input  valid, conn_state, reply_kind, segment_dropped, event_kind,
             recv_next_out, send_unacked_out,
      output ready
   );
endinterface

// ===== design/tcp_connection_state_step_top.sv =====
// top level of the tcp connection state step block: input register, step, result register
//
// one tcp connection: each request beat is either an incoming segment header
// (op 0) or a state load from the application (op 1); each request beat gives
// exactly one result beat with the new state, the reply to send, the drop flag,
// an event and the receive-next and send-unacknowledged pointers
// channels: req_bus (sink) and rsp_bus (source), valid/ready, a beat moves on
// a rising edge with valid and ready both high
// path: a request beat is held in the input register, then the step logic writes
// the result register and the connection state together once the result slot is free
// throughput: one beat per cycle while rsp_bus.ready keeps the result slot free;
// the state update loops through the step logic with no register but the state
// itself, so back-to-back segments see each other's state
// reset (synchronous, active high): state CLOSED, both pointers zero, both
// pipeline stages empty
// stall: while rsp_bus.ready is low the result register holds; the input
// register still fills, and only then does req_bus.ready drop
module tcp_connection_state_step_top (
   input  logic        clock,
   input  logic        reset,
   tcss_req_if.sink    req_bus,
   tcss_rsp_if.source  rsp_bus
);

   // input register
   logic              s1_valid_ff;
   logic              s1_valid_in;
   tcss_pkg::req_type s1_req_ff;
   tcss_pkg::req_type s1_req_in;

   // connection state
   tcss_pkg::conn_type conn_ff;
   tcss_pkg::conn_type conn_in;
   tcss_pkg::conn_type conn_step;

   // result register
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   tcss_pkg::rsp_type rsp_ff;
   tcss_pkg::rsp_type rsp_in;
   tcss_pkg::rsp_type rsp_step;

   logic req_take;
   logic s1_advance;
   logic rsp_free;

   // result slot frees when empty or being taken
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign s1_advance    = s1_valid_ff && rsp_free;
   assign req_bus.ready = !s1_valid_ff || rsp_free;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      s1_req_in.op          = req_bus.op;
      s1_req_in.new_state   = req_bus.new_state;
      s1_req_in.seg_seq     = req_bus.seg_seq;
      s1_req_in.seg_seq_end = req_bus.seg_seq_end;
      s1_req_in.seg_ack     = req_bus.seg_ack;
      s1_req_in.seg_flags   = req_bus.seg_flags;
      s1_req_in.send_next   = req_bus.send_next;
      s1_req_in.recv_window = req_bus.recv_window;
   end

   assign s1_valid_in = req_take || (s1_valid_ff && !s1_advance);

   tcss_step u_step (
      .req       (s1_req_ff),
      .conn      (conn_ff),
      .conn_next (conn_step),
      .rsp       (rsp_step)
   );

   // state and result commit together when the held beat moves on
   assign conn_in      = s1_advance ? conn_step : conn_ff;
   assign rsp_in       = s1_advance ? rsp_step : rsp_ff;
   assign rsp_valid_in = s1_advance || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         conn_ff.conn_state   <= tcss_pkg::ST_CLOSED;
         conn_ff.recv_next    <= 32'd0;
         conn_ff.send_unacked <= 32'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         conn_ff      <= conn_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff <= s1_req_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.conn_state       = rsp_ff.conn_state;
   assign rsp_bus.reply_kind       = rsp_ff.reply_kind;
   assign rsp_bus.segment_dropped  = rsp_ff.segment_dropped;
   assign rsp_bus.event_kind       = rsp_ff.event_kind;
   assign rsp_bus.recv_next_out    = rsp_ff.recv_next_out;
   assign rsp_bus.send_unacked_out = rsp_ff.send_unacked_out;

   // a beat leaving the input register always lands in the result register
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid_ff)
      else $error("input beat advanced but no result was registered");

   // a dropped segment carries no reply and no event
   a_drop_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.segment_dropped) |->
         (rsp_ff.reply_kind == tcss_pkg::RP_NONE && rsp_ff.event_kind == tcss_pkg::EV_NONE))
      else $error("dropped segment reported a reply or event");

   // a spawn leaves the listener in place and answers with syn plus ack
   a_spawn_listen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.event_kind == tcss_pkg::EV_SPAWN) |->
         (rsp_ff.conn_state == tcss_pkg::ST_LISTEN && rsp_ff.reply_kind == tcss_pkg::RP_SYNACK))
      else $error("spawn event without listen state and syn-ack reply");

   // the connection state only changes when a beat is stepped
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_advance |=> $stable(conn_ff))
      else $error("connection state changed without a stepped beat");

endmodule

// ===== design/tcss_step.sv =====
// combinational connection state step for one request beat
module tcss_step (
   input  tcss_pkg::req_type  req,
   input  tcss_pkg::conn_type conn,
   output tcss_pkg::conn_type conn_next,
   output tcss_pkg::rsp_type  rsp
);

   logic [31:0] win;
   logic [31:0] rcv_end;
   logic [31:0] seq_diff;
   logic [31:0] end_diff;
   logic        in_window;
   logic [31:0] seq_plus1;
   logic        ack_match;
   tcss_pkg::reply_type reply;
   tcss_pkg::event_type evt;
   logic        dropped;

   // window check, modulo 2^32
   assign win       = (req.recv_window > 16'd1) ? {16'd0, req.recv_window} : 32'd1;
   assign rcv_end   = conn.recv_next + win;
   assign seq_diff  = req.seg_seq - rcv_end;
   assign end_diff  = req.seg_seq_end - conn.recv_next;
   assign in_window = seq_diff[31] && !end_diff[31];
   assign seq_plus1 = req.seg_seq + 32'd1;
   assign ack_match = (req.seg_ack == req.send_next);

   always_comb begin
      conn_next = conn;
      reply     = tcss_pkg::RP_NONE;
      evt       = tcss_pkg::EV_NONE;
      dropped   = 1'b0;
      if (req.op == tcss_pkg::OP_SET_STATE) begin
         if (req.new_state <= tcss_pkg::ST_TIME_WAIT) begin
            conn_next.conn_state = tcss_pkg::conn_state_type'(req.new_state);
         end
      end else begin
         case (conn.conn_state)
            tcss_pkg::ST_CLOSED: begin
               reply = tcss_pkg::RP_RESET;
            end
            tcss_pkg::ST_LISTEN: begin
               reply = tcss_pkg::RP_SYNACK;
               evt   = tcss_pkg::EV_SPAWN;
            end
            tcss_pkg::ST_SYN_SENT: begin
               if (req.seg_flags[tcss_pkg::FL_SYN] && req.seg_flags[tcss_pkg::FL_ACK]) begin
                  conn_next.recv_next    = seq_plus1;
                  conn_next.send_unacked = req.seg_ack;
                  conn_next.conn_state   = tcss_pkg::ST_ESTABLISHED;
                  reply = tcss_pkg::RP_ACK;
                  evt   = tcss_pkg::EV_CONNECTED;
               end else begin
                  reply = tcss_pkg::RP_RESET;
               end
            end
            default: begin
               if (!in_window) begin
                  dropped = 1'b1;
               end else if (req.seg_flags[tcss_pkg::FL_RST]) begin
                  conn_next.conn_state = tcss_pkg::ST_CLOSED;
                  evt = tcss_pkg::EV_RESET;
               end else if (req.seg_flags[tcss_pkg::FL_SYN]) begin
                  conn_next.conn_state = tcss_pkg::ST_CLOSED;
                  reply = tcss_pkg::RP_RESET;
               end else if (!req.seg_flags[tcss_pkg::FL_ACK]) begin
                  reply = tcss_pkg::RP_RESET;
               end else begin
                  conn_next.send_unacked = req.seg_ack;
                  conn_next.recv_next    = req.seg_seq_end;
                  case (conn.conn_state)
                     tcss_pkg::ST_SYN_RECV: begin
                        if (ack_match) begin
                           conn_next.conn_state = tcss_pkg::ST_ESTABLISHED;
                           evt = tcss_pkg::EV_ACCEPT;
                        end
                     end
                     tcss_pkg::ST_FIN_WAIT_1: begin
                        if (ack_match) begin
                           conn_next.conn_state = tcss_pkg::ST_FIN_WAIT_2;
                        end
                     end
                     tcss_pkg::ST_FIN_WAIT_2: begin
                        if (req.seg_flags[tcss_pkg::FL_FIN]) begin
                           conn_next.recv_next  = seq_plus1;
                           conn_next.conn_state = tcss_pkg::ST_TIME_WAIT;
                           evt   = tcss_pkg::EV_TIMEWAIT;
                           reply = tcss_pkg::RP_ACK;
                        end
                     end
                     tcss_pkg::ST_ESTABLISHED: begin
                        if (req.seg_flags[tcss_pkg::FL_FIN]) begin
                           conn_next.recv_next  = seq_plus1;
                           conn_next.conn_state = tcss_pkg::ST_CLOSE_WAIT;
                           reply = tcss_pkg::RP_ACK;
                        end
                        if (req.seg_flags == tcss_pkg::FLAGS_ACK_ONLY) begin
                           reply = tcss_pkg::RP_ACK;
                        end
                     end
                     tcss_pkg::ST_LAST_ACK: begin
                        if (ack_match) begin
                           conn_next.conn_state = tcss_pkg::ST_CLOSED;
                        end
                     end
                     default: begin
                        // pointers only
                     end
                  endcase
               end
            end
         endcase
      end
   end

   always_comb begin
      rsp.conn_state       = conn_next.conn_state;
      rsp.reply_kind       = reply;
      rsp.segment_dropped  = dropped;
      rsp.event_kind       = evt;
      rsp.recv_next_out    = (evt == tcss_pkg::EV_SPAWN) ? req.seg_seq_end
                                                         : conn_next.recv_next;
      rsp.send_unacked_out = conn_next.send_unacked;
   end

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for the tcp connection state step block: random and directed beats
module testbench;
   import tcss_pkg::*;

   // run length and pacing
   localparam int LIMIT_CYCLES = 400000;
   localparam int RANDOM_BEATS = 1650;
   localparam int CALM_TAIL    = 150;
   localparam int DRAIN_CYCLES = 8;

   // flag masks built from the package bit positions; psh and urg are not in the package
   localparam logic [5:0] F_FIN = 6'd1 << FL_FIN;
   localparam logic [5:0] F_SYN = 6'd1 << FL_SYN;
   localparam logic [5:0] F_RST = 6'd1 << FL_RST;
   localparam logic [5:0] F_ACK = 6'd1 << FL_ACK;
   localparam logic [5:0] F_PSH = 6'b00_1000;
   localparam logic [5:0] F_URG = 6'b10_0000;

   logic clock;
   logic reset;

   tcss_req_if req_bus ();
   tcss_rsp_if rsp_bus ();

   tcp_connection_state_step_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // beats still to be offered, and results owed by the block
   req_type  pending_beats[$];
   rsp_type  due_results[$];

   // plan_conn tracks the connection while the stimulus is built, so that
   // segments can be aimed at the receive window; live_conn follows the
   // beats the block actually takes
   conn_type plan_conn;
   conn_type live_conn;

   logic req_beat;      // a request beat moved at the last rising edge
   int   total_beats;
   int   beats_taken;
   int   send_gap;
   int   stall_gap;
   int   mismatches;
   int   cycles;

   // target states for a state load, picked for most of the loads
   conn_state_type goals [7] = '{ST_SYN_SENT, ST_SYN_RECV, ST_ESTABLISHED, ST_FIN_WAIT_1,
                                 ST_FIN_WAIT_2, ST_LAST_ACK, ST_LISTEN};

   always #5 clock = ~clock;

   // one step of the connection: updates c and returns the result beat
   function automatic rsp_type tcp_step(inout conn_type c, input req_type r);
      rsp_type        o;
      conn_state_type held;
      logic [31:0]    win_end;
      logic [31:0]    lead;
      logic [31:0]    trail;
      held = c.conn_state;
      o.reply_kind = RP_NONE;
      o.segment_dropped = 1'b0;
      o.event_kind = EV_NONE;
      if (r.op == OP_SET_STATE) begin
         // codes above time-wait are ignored, state kept
         if (r.new_state <= ST_TIME_WAIT) c.conn_state = conn_state_type'(r.new_state);
      end else begin
         case (held)
            ST_CLOSED: o.reply_kind = RP_RESET;
            ST_LISTEN: begin
               o.reply_kind = RP_SYNACK;
               o.event_kind = EV_SPAWN;
            end
            ST_SYN_SENT: begin
               if (r.seg_flags[FL_SYN] && r.seg_flags[FL_ACK]) begin
                  c.recv_next = r.seg_seq + 32'd1;
                  c.send_unacked = r.seg_ack;
                  c.conn_state = ST_ESTABLISHED;
                  o.reply_kind = RP_ACK;
                  o.event_kind = EV_CONNECTED;
               end else begin
                  o.reply_kind = RP_RESET;
               end
            end
            default: begin
               // modulo-2^32 window: seq before recv_next + max(window, 1),
               // and seq_end not behind recv_next
               win_end = c.recv_next + ((r.recv_window > 16'd1) ? {16'd0, r.recv_window} : 32'd1);
               lead = r.seg_seq - win_end;
               trail = r.seg_seq_end - c.recv_next;
               if (!lead[31] || trail[31]) begin
                  o.segment_dropped = 1'b1;
               end else if (r.seg_flags[FL_RST]) begin
                  c.conn_state = ST_CLOSED;
                  o.event_kind = EV_RESET;
               end else if (r.seg_flags[FL_SYN]) begin
                  c.conn_state = ST_CLOSED;
                  o.reply_kind = RP_RESET;
               end else if (!r.seg_flags[FL_ACK]) begin
                  o.reply_kind = RP_RESET;
               end else begin
                  c.send_unacked = r.seg_ack;
                  c.recv_next = r.seg_seq_end;
                  if (held == ST_SYN_RECV) begin
                     if (r.seg_ack == r.send_next) begin
                        c.conn_state = ST_ESTABLISHED;
                        o.event_kind = EV_ACCEPT;
                     end
                  end else if (held == ST_FIN_WAIT_1) begin
                     if (r.seg_ack == r.send_next) c.conn_state = ST_FIN_WAIT_2;
                  end else if (held == ST_FIN_WAIT_2) begin
                     if (r.seg_flags[FL_FIN]) begin
                        c.recv_next = r.seg_seq + 32'd1;
                        c.conn_state = ST_TIME_WAIT;
                        o.reply_kind = RP_ACK;
                        o.event_kind = EV_TIMEWAIT;
                     end
                  end else if (held == ST_ESTABLISHED) begin
                     if (r.seg_flags[FL_FIN]) begin
                        c.recv_next = r.seg_seq + 32'd1;
                        c.conn_state = ST_CLOSE_WAIT;
                        o.reply_kind = RP_ACK;
                     end
                     if (r.seg_flags == FLAGS_ACK_ONLY) o.reply_kind = RP_ACK;
                  end else if (held == ST_LAST_ACK) begin
                     if (r.seg_ack == r.send_next) c.conn_state = ST_CLOSED;
                  end
               end
            end
         endcase
      end
      o.conn_state = c.conn_state;
      // on a spawn the pointer reported is the child's receive-next
      o.recv_next_out = (o.event_kind == EV_SPAWN) ? r.seg_seq_end : c.recv_next;
      o.send_unacked_out = c.send_unacked;
      return o;
   endfunction

   function automatic void queue_beat(req_type r);
      void'(tcp_step(plan_conn, r));
      pending_beats.push_back(r);
   endfunction

   function automatic void queue_load(logic [3:0] target);
      req_type r;
      r.op = OP_SET_STATE;
      r.new_state = target;
      r.seg_seq = $urandom;
      r.seg_seq_end = $urandom;
      r.seg_ack = $urandom;
      r.seg_flags = 6'($urandom);
      r.send_next = $urandom;
      r.recv_window = 16'($urandom);
      queue_beat(r);
   endfunction

   function automatic void queue_seg(logic [31:0] seq, logic [31:0] seq_end, logic [31:0] ack,
                                     logic [5:0] flags, logic [31:0] snd, logic [15:0] wnd);
      req_type r;
      r.op = OP_SEGMENT;
      r.new_state = 4'($urandom);
      r.seg_seq = seq;
      r.seg_seq_end = seq_end;
      r.seg_ack = ack;
      r.seg_flags = flags;
      r.send_next = snd;
      r.recv_window = wnd;
      queue_beat(r);
   endfunction

   // segment that lands inside the current receive window
   function automatic void queue_fit(logic [5:0] flags, int unsigned len, bit ack_hit,
                                     logic [15:0] wnd);
      logic [31:0] seq;
      logic [31:0] snd;
      int unsigned span;
      span = (wnd > 16'd1) ? int'(wnd) : 1;
      seq = plan_conn.recv_next + $urandom_range(0, span - 1);
      snd = $urandom;
      queue_seg(seq, seq + len, ack_hit ? snd : $urandom, flags, snd, wnd);
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s expected %0h got %0h", name, want, got);
         mismatches++;
      end
   endtask

   // request side: take a beat into the prediction at each rising edge it moves
   always @(posedge clock) begin
      req_beat <= !reset && req_bus.valid && req_bus.ready;
      if (reset) begin
         live_conn = '{ST_CLOSED, 32'd0, 32'd0};
      end else if (req_bus.valid && req_bus.ready) begin : take_req
         req_type seen;
         seen.op = req_bus.op;
         seen.new_state = req_bus.new_state;
         seen.seg_seq = req_bus.seg_seq;
         seen.seg_seq_end = req_bus.seg_seq_end;
         seen.seg_ack = req_bus.seg_ack;
         seen.seg_flags = req_bus.seg_flags;
         seen.send_next = req_bus.send_next;
         seen.recv_window = req_bus.recv_window;
         due_results.push_back(tcp_step(live_conn, seen));
         beats_taken++;
      end
   end

   // result side: every beat is matched against the oldest owed result
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin : take_rsp
         rsp_type want;
         if (due_results.size() == 0) begin
            $error("result beat with no result owed");
            mismatches++;
         end else begin
            want = due_results.pop_front();
            check_field("conn_state", 32'(want.conn_state), 32'(rsp_bus.conn_state));
            check_field("reply_kind", 32'(want.reply_kind), 32'(rsp_bus.reply_kind));
            check_field("segment_dropped", 32'(want.segment_dropped),
                        32'(rsp_bus.segment_dropped));
            check_field("event_kind", 32'(want.event_kind), 32'(rsp_bus.event_kind));
            check_field("recv_next_out", want.recv_next_out, rsp_bus.recv_next_out);
            check_field("send_unacked_out", want.send_unacked_out, rsp_bus.send_unacked_out);
         end
      end
   end

   // driver: valid holds until the beat moves, gaps come in bursts
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_beat) begin : offer
         req_type nb;
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (total_beats - beats_taken > CALM_TAIL && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 18);
            req_bus.valid <= 1'b0;
         end else if (pending_beats.size() != 0) begin
            nb = pending_beats.pop_front();
            req_bus.op <= nb.op;
            req_bus.new_state <= nb.new_state;
            req_bus.seg_seq <= nb.seg_seq;
            req_bus.seg_seq_end <= nb.seg_seq_end;
            req_bus.seg_ack <= nb.seg_ack;
            req_bus.seg_flags <= nb.seg_flags;
            req_bus.send_next <= nb.send_next;
            req_bus.recv_window <= nb.recv_window;
            req_bus.valid <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // receiver: stalls in bursts too, none near the end
   always @(negedge clock) begin
      if (stall_gap > 0) begin
         stall_gap--;
         rsp_bus.ready <= 1'b0;
      end else if (total_beats - beats_taken > CALM_TAIL && $urandom_range(0, 7) == 0) begin
         stall_gap = $urandom_range(0, 18);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("FAIL tcp_connection_state_step_top");
         $finish;
      end
   end

   initial begin
      conn_state_type st;
      logic [15:0]    wnd;
      logic [5:0]     flags;
      logic [5:0]     extra;
      int             pick;
      int             kind;
      bit             parked;

      clock = 1'b0;
      reset = 1'b1;
      req_beat = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.op = OP_SEGMENT;
      req_bus.new_state = 4'd0;
      req_bus.seg_seq = 32'd0;
      req_bus.seg_seq_end = 32'd0;
      req_bus.seg_ack = 32'd0;
      req_bus.seg_flags = 6'd0;
      req_bus.send_next = 32'd0;
      req_bus.recv_window = 16'd0;
      rsp_bus.ready = 1'b0;
      beats_taken = 0;
      send_gap = 0;
      stall_gap = 0;
      mismatches = 0;
      cycles = 0;
      plan_conn = '{ST_CLOSED, 32'd0, 32'd0};
      live_conn = '{ST_CLOSED, 32'd0, 32'd0};

      // directed: closed answers with a reset, all fields at their top
      queue_seg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F, 32'hFFFF_FFFF, 16'hFFFF);
      // listen spawns a child, child's receive-next is seq_end
      queue_load(ST_LISTEN);
      queue_seg(32'd0, 32'hFFFF_FFFF, 32'd0, F_SYN, 32'd0, 16'd0);
      // unknown state code is ignored
      queue_load(4'hF);
      // active open: syn alone refused, then syn+ack at seq wrap point
      queue_load(ST_SYN_SENT);
      queue_seg(32'h1234_5678, 32'h1234_5679, 32'd0, F_SYN, 32'd0, 16'd100);
      queue_seg(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_1000, F_SYN | F_ACK, 32'd0, 16'd0);
      // established traffic: zero window counts as one, then the widest window
      queue_fit(FLAGS_ACK_ONLY, 100, 1'b1, 16'd0);
      queue_fit(F_ACK | F_PSH, 64, 1'b0, 16'hFFFF);
      // just past the window end, then wholly behind recv_next
      queue_seg(plan_conn.recv_next + 32'd65535, plan_conn.recv_next + 32'd65600, 32'd0,
                F_ACK, 32'd0, 16'hFFFF);
      queue_seg(plan_conn.recv_next - 32'd10, plan_conn.recv_next - 32'd1, 32'd0,
                F_ACK, 32'd0, 16'hFFFF);
      // missing ack gets a reset
      queue_fit(F_PSH, 10, 1'b0, 16'd500);
      // peer closes
      queue_fit(F_FIN | F_ACK, 1, 1'b0, 16'd500);
      queue_load(ST_LAST_ACK);
      queue_fit(F_ACK, 0, 1'b0, 16'd500);
      queue_fit(F_ACK, 0, 1'b1, 16'd500);
      // passive open completes
      queue_load(ST_SYN_RECV);
      queue_fit(F_ACK, 0, 1'b1, 16'd1);
      // active close through to time-wait
      queue_load(ST_FIN_WAIT_1);
      queue_fit(F_ACK, 0, 1'b1, 16'd800);
      queue_fit(F_FIN | F_ACK, 1, 1'b0, 16'd800);
      // rst and syn inside the window both close
      queue_load(ST_ESTABLISHED);
      queue_fit(F_RST | F_ACK, 0, 1'b0, 16'd800);
      queue_load(ST_ESTABLISHED);
      queue_fit(F_SYN | F_ACK, 0, 1'b0, 16'd800);
      queue_load(ST_CLOSING);
      queue_fit(F_ACK | F_URG, 20, 1'b0, 16'd800);

      // random: mostly segments aimed at the window for the state at hand
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         st = plan_conn.conn_state;
         pick = $urandom_range(0, 99);
         wnd = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 1)) : 16'($urandom);
         parked = (st == ST_CLOSED) || (st == ST_LISTEN) || (st == ST_CLOSE_WAIT) ||
                  (st == ST_CLOSING) || (st == ST_TIME_WAIT);
         if (pick < (parked ? 35 : 7)) begin
            if ($urandom_range(0, 9) < 7) queue_load(goals[3'($urandom_range(0, 6))]);
            else queue_load(4'($urandom_range(0, 15)));
         end else if (pick < 88) begin
            if (st == ST_SYN_SENT) begin
               flags = ($urandom_range(0, 4) == 0) ? 6'($urandom)
                                                   : (6'($urandom) | F_SYN | F_ACK);
               queue_seg($urandom, $urandom, $urandom, flags, $urandom, wnd);
            end else if (st == ST_CLOSED || st == ST_LISTEN) begin
               queue_seg($urandom, $urandom, $urandom, 6'($urandom), $urandom, wnd);
            end else begin
               kind = $urandom_range(0, 19);
               extra = 6'($urandom) & (F_PSH | F_URG);
               if (kind == 0) flags = F_RST | 6'($urandom);
               else if (kind == 1) flags = (F_SYN | 6'($urandom)) & ~F_RST;
               else if (kind == 2) flags = 6'($urandom) & ~(F_RST | F_SYN | F_ACK);
               else if (kind < 10) flags = FLAGS_ACK_ONLY;
               else if (kind < 15) flags = F_ACK | F_FIN | extra;
               else flags = F_ACK | extra | (6'($urandom) & F_FIN);
               queue_fit(flags, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 1460),
                         $urandom_range(0, 9) < 6, wnd);
            end
         end else begin
            // noise: anything at all, mostly out of the window
            queue_seg($urandom, $urandom, $urandom, 6'($urandom), $urandom, wnd);
         end
      end
      total_beats = pending_beats.size();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every beat taken and every result back, then a short drain for strays
      while (beats_taken != total_beats || due_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatches == 0) begin
         $display("PASS tcp_connection_state_step_top");
      end else begin
         $display("FAIL tcp_connection_state_step_top");
      end
      $finish;
   end

endmodule
